/* rtl/rbfr_pkg.sv */
// Shared types and constants for the reversible blur/fade ramp controller.
// Used by rbfr_scale and reversible_blur_fade_ramp; depends on nothing else.
package rbfr_pkg;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_FULL_TIME      = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BLUR_RAMP_TIME = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FADE_DELAY     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BLUR_MAX       = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FADE_MAX       = 3'd4;

   // Register values after reset.
   localparam int RST_FULL_TIME      = 1000;
   localparam int RST_BLUR_RAMP_TIME = 250;
   localparam int RST_FADE_DELAY     = 250;
   localparam int RST_BLUR_MAX       = 65535;
   localparam int RST_FADE_MAX       = 65535;

   // Item operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_TOGGLE = 1'b1;

   typedef enum logic [1:0] {
      PH_OFF  = 2'd0,
      PH_RISE = 2'd1,
      PH_FALL = 2'd2,
      PH_ON   = 2'd3
   } rbfr_phase_type;

   typedef struct packed {
      logic        operation;
      logic [15:0] delta_time;
   } rbfr_req_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic        busy_res;
      logic [15:0] blur_level;
      logic [15:0] fade_level;
   } rbfr_rsp_type;

   // Sequencer of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_BLUR,
      ST_BLUR_WAIT,
      ST_FADE,
      ST_FADE_WAIT,
      ST_DONE
   } rbfr_state_type;

   // Sequencer of the shared multiply/divide unit.
   typedef enum logic [1:0] {
      SC_IDLE,
      SC_MUL,
      SC_DIV,
      SC_DONE
   } rbfr_scale_state_type;

endpackage

/* rtl/rbfr_scale.sv */
// Shared scaling unit: quotient = num * maxv / den, truncated, maxv when den is zero.
// One registered multiply, then a restoring divider that retires one quotient bit a cycle.
// Depends on rbfr_pkg.
module rbfr_scale
   import rbfr_pkg::*;
#(
   parameter int TIME_BITS  = 16,
   parameter int LEVEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_BITS-1:0]  num,
   input  logic [LEVEL_BITS-1:0] maxv,
   input  logic [TIME_BITS-1:0]  den,
   output logic                  done,
   output logic [LEVEL_BITS-1:0] quot
);

   localparam int CNT_BITS = $clog2(LEVEL_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(LEVEL_BITS - 1);

   rbfr_scale_state_type state_ff, state_in;

   logic [TIME_BITS-1:0]            num_ff, den_ff;
   logic [LEVEL_BITS-1:0]           maxv_ff;
   logic [TIME_BITS-1:0]            rem_ff, rem_in;
   logic [LEVEL_BITS-1:0]           quo_ff, quo_in;
   logic [CNT_BITS-1:0]             cnt_ff, cnt_in;
   logic [TIME_BITS+LEVEL_BITS-1:0] product;
   logic [TIME_BITS:0]              trial, diff;
   logic                            fits;
   logic                            den_zero;

   // The quotient fits in LEVEL_BITS because num never exceeds den, so the
   // upper part of the product starts below den and only LEVEL_BITS steps remain.
   assign product  = num_ff * maxv_ff;
   assign trial    = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign fits     = trial >= {1'b0, den_ff};
   assign den_zero = (den_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               state_in = SC_MUL;
            end
         end
         SC_MUL:  state_in = SC_DIV;
         SC_DIV: begin
            if (cnt_ff == LAST_STEP) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: state_in = SC_IDLE;
         default: state_in = SC_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == SC_DONE);
      quot = den_zero ? maxv_ff : quo_ff;
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         SC_MUL: begin
            rem_in = product[TIME_BITS+LEVEL_BITS-1:LEVEL_BITS];
            quo_in = product[LEVEL_BITS-1:0];
            cnt_in = '0;
         end
         SC_DIV: begin
            rem_in = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            quo_in = {quo_ff[LEVEL_BITS-2:0], fits};
            cnt_in = cnt_ff + CNT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SC_IDLE && start) begin
         num_ff  <= num;
         maxv_ff <= maxv;
         den_ff  <= den;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == SC_IDLE)
      else $error("scale unit started while busy");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("scale done held for more than one cycle");

   a_quot_bounded: assert property (@(posedge clock) disable iff (reset)
      done |-> quot <= maxv_ff)
      else $error("scaled level exceeds its maximum");

endmodule

/* rtl/reversible_blur_fade_ramp.sv */
// Top level of the reversible blur/fade ramp controller: registers, phase state and sequencer.
// Depends on rbfr_pkg and rbfr_scale.
//
//   Channel  Ports                               Direction  Moves
//   req      req_valid, req_stall, req_data      in         one operation item
//   rsp      rsp_valid, rsp_stall, rsp_data      out        one result item per request
//   csr      csr_we, csr_addr, csr_wdata         in         register write, no read-back
//
// A toggle, or a tick that ends a ramp or finds the block complete, goes from the update state straight to done.
// A tick inside a ramp goes on to compute the levels:
// blur and fade are computed one after the other on one shared multiply/divide unit,
// whose divider produces one quotient bit per cycle.
// Reset is synchronous; it restores the register defaults and the complete-off phase.
// A new item is accepted while a result waits on a stalled rsp channel.
module reversible_blur_fade_ramp
   import rbfr_pkg::*;
#(
   parameter int TIME_BITS  = 16,
   parameter int LEVEL_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rbfr_req_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rbfr_rsp_type             rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int TW = TIME_BITS + CSR_DATA_BITS;
   localparam int LW = LEVEL_BITS + CSR_DATA_BITS;

   localparam logic [TIME_BITS-1:0]  FULL_RST  = TIME_BITS'(RST_FULL_TIME);
   localparam logic [TIME_BITS-1:0]  BRAMP_RST = TIME_BITS'(RST_BLUR_RAMP_TIME);
   localparam logic [TIME_BITS-1:0]  DELAY_RST = TIME_BITS'(RST_FADE_DELAY);
   localparam logic [LEVEL_BITS-1:0] BMAX_RST  = LEVEL_BITS'(RST_BLUR_MAX);
   localparam logic [LEVEL_BITS-1:0] FMAX_RST  = LEVEL_BITS'(RST_FADE_MAX);

   // Configuration registers.
   logic [TIME_BITS-1:0]  full_ff, bramp_ff, delay_ff;
   logic [LEVEL_BITS-1:0] bmax_ff, fmax_ff;
   logic [TW-1:0]         wdata_twide;
   logic [LW-1:0]         wdata_lwide;
   logic [TIME_BITS-1:0]  wdata_time;
   logic [LEVEL_BITS-1:0] wdata_level;

   // Controller state and the item being worked on.
   rbfr_state_type        state_ff, state_in;
   rbfr_phase_type        phase_ff, phase_in;
   logic [TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [LEVEL_BITS-1:0] blur_ff, blur_in, fade_ff, fade_in;
   logic                  op_ff;
   logic [TIME_BITS-1:0]  delta_ff;
   logic [TW-1:0]         delta_wide;

   // Result register.
   logic                  rsp_valid_ff;
   rbfr_rsp_type          rsp_ff, rsp_in;
   logic [LW-1:0]         blur_out_wide, fade_out_wide;

   // Sequencer outputs.
   logic                  accept;
   logic                  scl_start;
   logic                  load_rsp;

   // Update and ramp arithmetic.
   logic                  in_ramp;
   logic                  rising;
   logic [TIME_BITS:0]    sum;
   logic                  reach_full;
   logic                  tick_continues;
   logic [TIME_BITS-1:0]  rest;
   logic [TIME_BITS-1:0]  blur_num;
   logic                  blur_need;
   logic [TIME_BITS:0]    t_plus_d;
   logic                  fade_need;
   logic [TIME_BITS-1:0]  fade_num, fade_den;
   logic [TIME_BITS-1:0]  scl_num, scl_den;
   logic [LEVEL_BITS-1:0] scl_maxv;
   logic                  scl_done;
   logic [LEVEL_BITS-1:0] scl_quot;

   assign wdata_twide = TW'(csr_wdata);
   assign wdata_lwide = LW'(csr_wdata);
   assign wdata_time  = wdata_twide[TIME_BITS-1:0];
   assign wdata_level = wdata_lwide[LEVEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= FULL_RST;
         bramp_ff <= BRAMP_RST;
         delay_ff <= DELAY_RST;
         bmax_ff  <= BMAX_RST;
         fmax_ff  <= FMAX_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FULL_TIME:      full_ff  <= wdata_time;
            CSR_BLUR_RAMP_TIME: bramp_ff <= wdata_time;
            CSR_FADE_DELAY:     delay_ff <= wdata_time;
            CSR_BLUR_MAX:       bmax_ff  <= wdata_level;
            CSR_FADE_MAX:       fmax_ff  <= wdata_level;
            default: begin
            end
         endcase
      end
   end

   // Tick arithmetic on the state as it was before the item.
   assign in_ramp        = (phase_ff == PH_RISE) || (phase_ff == PH_FALL);
   assign sum            = {1'b0, elapsed_ff} + {1'b0, delta_ff};
   assign reach_full     = sum >= {1'b0, full_ff};
   assign tick_continues = (op_ff == OP_TICK) && in_ramp && !reach_full;

   // Level operands on the updated timer, which is below full time here.
   assign rising    = (phase_ff == PH_RISE);
   assign rest      = full_ff - elapsed_ff;
   assign blur_num  = rising ? elapsed_ff : rest;
   assign blur_need = blur_num < bramp_ff;
   assign t_plus_d  = {1'b0, elapsed_ff} + {1'b0, delay_ff};
   assign fade_den  = full_ff - delay_ff;
   assign fade_num  = rising ? (elapsed_ff - delay_ff) : (fade_den - elapsed_ff);
   assign fade_need = rising ? (elapsed_ff > delay_ff) : (t_plus_d < {1'b0, full_ff});

   always_comb begin
      if (state_ff == ST_FADE) begin
         scl_num  = fade_num;
         scl_den  = fade_den;
         scl_maxv = fmax_ff;
      end else begin
         scl_num  = blur_num;
         scl_den  = bramp_ff;
         scl_maxv = bmax_ff;
      end
   end

   rbfr_scale #(
      .TIME_BITS  (TIME_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_scale (
      .clock (clock),
      .reset (reset),
      .start (scl_start),
      .num   (scl_num),
      .maxv  (scl_maxv),
      .den   (scl_den),
      .done  (scl_done),
      .quot  (scl_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = tick_continues ? ST_BLUR : ST_DONE;
         end
         ST_BLUR: begin
            state_in = blur_need ? ST_BLUR_WAIT : ST_FADE;
         end
         ST_BLUR_WAIT: begin
            if (scl_done) begin
               state_in = ST_FADE;
            end
         end
         ST_FADE: begin
            state_in = fade_need ? ST_FADE_WAIT : ST_DONE;
         end
         ST_FADE_WAIT: begin
            if (scl_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      scl_start = ((state_ff == ST_BLUR) && blur_need) || ((state_ff == ST_FADE) && fade_need);
      load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   assign accept     = req_valid && !req_stall;
   assign delta_wide = TW'(req_data.delta_time);

   // Phase, timer and level updates.
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      blur_in    = blur_ff;
      fade_in    = fade_ff;
      unique case (state_ff)
         ST_UPDATE: begin
            if (op_ff == OP_TOGGLE) begin
               if (in_ramp) begin
                  // Reversal: the time left in the old direction becomes the time done.
                  phase_in   = rising ? PH_FALL : PH_RISE;
                  elapsed_in = (elapsed_ff <= full_ff) ? (full_ff - elapsed_ff) : '0;
               end else begin
                  phase_in   = (phase_ff == PH_ON) ? PH_FALL : PH_RISE;
                  elapsed_in = '0;
               end
            end else if (in_ramp) begin
               if (reach_full) begin
                  phase_in   = rising ? PH_ON : PH_OFF;
                  blur_in    = rising ? bmax_ff : '0;
                  fade_in    = rising ? fmax_ff : '0;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = sum[TIME_BITS-1:0];
               end
            end
         end
         ST_BLUR: begin
            if (!blur_need) begin
               blur_in = bmax_ff;
            end
         end
         ST_BLUR_WAIT: begin
            if (scl_done) begin
               blur_in = scl_quot;
            end
         end
         ST_FADE: begin
            if (!fade_need) begin
               fade_in = '0;
            end
         end
         ST_FADE_WAIT: begin
            if (scl_done) begin
               fade_in = scl_quot;
            end
         end
         default: begin
         end
      endcase
   end

   assign blur_out_wide = LW'(blur_ff);
   assign fade_out_wide = LW'(fade_ff);

   always_comb begin
      rsp_in.phase      = phase_ff;
      rsp_in.busy_res   = in_ramp;
      rsp_in.blur_level = blur_out_wide[CSR_DATA_BITS-1:0];
      rsp_in.fade_level = fade_out_wide[CSR_DATA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_OFF;
         elapsed_ff   <= '0;
         blur_ff      <= '0;
         fade_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         blur_ff    <= blur_in;
         fade_ff    <= fade_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_data.operation;
         delta_ff <= delta_wide[TIME_BITS-1:0];
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("accepted item did not start an update");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      scl_done |-> (state_ff == ST_BLUR_WAIT || state_ff == ST_FADE_WAIT))
      else $error("scale result arrived outside a wait state");

   a_busy_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.busy_res ==
         (rsp_ff.phase == PH_RISE || rsp_ff.phase == PH_FALL))
      else $error("busy flag disagrees with the reported phase");

   a_levels_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && $past(state_ff) == ST_FADE_WAIT)
         |-> (blur_ff <= bmax_ff && fade_ff <= fmax_ff))
      else $error("ramp level above its maximum");

   a_ramp_timer_below_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLUR |-> elapsed_ff < full_ff)
      else $error("level computation started with the timer at full time");

endmodule
